// File: hw/rtl/sh24_pkg.sv
// shared types, constants and the round function of the siphash-2-4 block
package sh24_pkg;

   localparam int unsigned WORD_W  = 64;
   localparam int unsigned COUNT_W = 4;
   localparam int unsigned LEN_W   = 8;
   localparam int unsigned BYTES   = WORD_W / 8;

   localparam logic [WORD_W-1:0] IV_A = 64'h736f6d6570736575;
   localparam logic [WORD_W-1:0] IV_B = 64'h646f72616e646f6d;
   localparam logic [WORD_W-1:0] IV_C = 64'h6c7967656e657261;
   localparam logic [WORD_W-1:0] IV_D = 64'h7465646279746573;
   localparam logic [WORD_W-1:0] FINAL_XOR = 64'h00000000000000ff;

   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(BYTES);
   localparam int unsigned FINAL_ROUNDS = 4;
   localparam int unsigned FIN_CNT_W = $clog2(FINAL_ROUNDS);

   typedef enum logic [0:0] {
      CSR_KEY_LOW  = 1'b0,
      CSR_KEY_HIGH = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WORD_R1,
      ST_WORD_R2,
      ST_TAIL_R1,
      ST_TAIL_R2,
      ST_FINAL
   } ctrl_state_type;

   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] c;
      logic [WORD_W-1:0] d;
   } lanes_type;

   typedef struct packed {
      logic accept;
      logic round;
      logic xor_a_block;
      logic chain_tail;
      logic xor_c_final;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic full;
      logic out_free;
   } status_type;

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                              input logic [5:0] s);
      rotl = (x << s) | (x >> (7'd64 - {1'b0, s}));
   endfunction

   function automatic lanes_type sip_round(input lanes_type s);
      lanes_type r;
      r = s;
      r.a = r.a + r.b;
      r.c = r.c + r.d;
      r.b = rotl(r.b, 6'd13) ^ r.a;
      r.d = rotl(r.d, 6'd16) ^ r.c;
      r.a = rotl(r.a, 6'd32);
      r.c = r.c + r.b;
      r.a = r.a + r.d;
      r.b = rotl(r.b, 6'd17) ^ r.c;
      r.d = rotl(r.d, 6'd21) ^ r.a;
      r.c = rotl(r.c, 6'd32);
      sip_round = r;
   endfunction

endpackage

// File: hw/rtl/siphash_2_4_keyed_hash.sv
// top level of the siphash-2-4 keyed hash over a stream of 64-bit words
// usage:
// key halves are written through the csr channel (index 0 low, 1 high),
// csr_ready is always high; keys take effect at the next message start
// each req beat carries one little-endian message word, its valid byte
// count and tlast on the final word of a message
// the round unit runs one siprounds per cycle while not held; a non-last word
// takes the accept plus two rounds, a last word two rounds and then the
// finalization rounds, with a separate length block of two rounds between them
// when it holds 8 bytes; the hash appears on rsp in the cycle after the last round
// and stays until taken; while it waits, the next message keeps being absorbed
// and only the final round of that message holds until the result register frees
// reset clears keys, lanes, length and any pending result
module siphash_2_4_keyed_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // message_word[63:0], byte_count[67:64], zero pad
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // hash_value[63:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [63:0] csr_data
);

   sh24_pkg::cmd_type    cmd;
   sh24_pkg::status_type status;

   assign csr_ready = 1'b1;

   sh24_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sh24_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .message_word (req_tdata[63:0]),
      .byte_count   (req_tdata[67:64]),
      .last         (req_tlast),
      .cmd          (cmd),
      .status       (status),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .hash_value   (rsp_tdata)
   );

`ifndef SYNTH
   a_one_word_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("new word accepted while previous word in progress");

   a_emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_tvalid || rsp_tready))
      else $error("hash emitted over an untaken result");

   a_emit_needs_round: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (cmd.round && !cmd.accept))
      else $error("emit without final round");
`endif

endmodule

// File: hw/rtl/sh24_ctrl.sv
// sequencer for word absorb, tail block and finalization rounds
module sh24_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  sh24_pkg::status_type status,
   output sh24_pkg::cmd_type    cmd
);

   sh24_pkg::ctrl_state_type state_ff, state_in;
   logic [sh24_pkg::FIN_CNT_W-1:0] fin_cnt_ff, fin_cnt_in;
   logic fin_done;

   assign fin_done = (fin_cnt_ff == sh24_pkg::FIN_CNT_W'(sh24_pkg::FINAL_ROUNDS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sh24_pkg::ST_IDLE;
         fin_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         fin_cnt_ff <= fin_cnt_in;
      end
   end

   // next state
   always_comb begin
      state_in   = state_ff;
      fin_cnt_in = fin_cnt_ff;
      case (state_ff)
         sh24_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = sh24_pkg::ST_WORD_R1;
            end
         end
         sh24_pkg::ST_WORD_R1: begin
            state_in = sh24_pkg::ST_WORD_R2;
         end
         sh24_pkg::ST_WORD_R2: begin
            fin_cnt_in = '0;
            if (!status.last) begin
               state_in = sh24_pkg::ST_IDLE;
            end else if (status.full) begin
               state_in = sh24_pkg::ST_TAIL_R1;
            end else begin
               state_in = sh24_pkg::ST_FINAL;
            end
         end
         sh24_pkg::ST_TAIL_R1: begin
            state_in = sh24_pkg::ST_TAIL_R2;
         end
         sh24_pkg::ST_TAIL_R2: begin
            fin_cnt_in = '0;
            state_in   = sh24_pkg::ST_FINAL;
         end
         sh24_pkg::ST_FINAL: begin
            if (!fin_done) begin
               fin_cnt_in = fin_cnt_ff + 1'b1;
            end else if (status.out_free) begin
               state_in = sh24_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sh24_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         sh24_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         sh24_pkg::ST_WORD_R1: begin
            cmd.round = 1'b1;
         end
         sh24_pkg::ST_WORD_R2: begin
            cmd.round       = 1'b1;
            cmd.xor_a_block = 1'b1;
            cmd.chain_tail  = status.last & status.full;
            cmd.xor_c_final = status.last & ~status.full;
         end
         sh24_pkg::ST_TAIL_R1: begin
            cmd.round = 1'b1;
         end
         sh24_pkg::ST_TAIL_R2: begin
            cmd.round       = 1'b1;
            cmd.xor_a_block = 1'b1;
            cmd.xor_c_final = 1'b1;
         end
         sh24_pkg::ST_FINAL: begin
            cmd.round = ~fin_done | status.out_free;
            cmd.emit  = fin_done & status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: hw/rtl/sh24_dp.sv
// lanes, key registers, round unit and result register
module sh24_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [0:0]                          csr_index,
   input  logic [sh24_pkg::WORD_W-1:0]         csr_data,
   input  logic [sh24_pkg::WORD_W-1:0]         message_word,
   input  logic [sh24_pkg::COUNT_W-1:0]        byte_count,
   input  logic                                last,
   input  sh24_pkg::cmd_type                   cmd,
   output sh24_pkg::status_type                status,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [sh24_pkg::WORD_W-1:0]         hash_value
);

   sh24_pkg::lanes_type lanes_ff, lanes_in, rnd, init, base;
   logic [sh24_pkg::WORD_W-1:0] key0_ff, key1_ff;
   logic [sh24_pkg::WORD_W-1:0] block_ff, block_in;
   logic [sh24_pkg::WORD_W-1:0] hash_ff, hash_in;
   logic [sh24_pkg::WORD_W-1:0] tail, len_block;
   logic [sh24_pkg::LEN_W-1:0]  len_ff, len_in, len_base, len_add;
   logic [sh24_pkg::COUNT_W-1:0] count_c;
   logic open_ff, open_in;
   logic last_ff, last_in;
   logic full_ff, full_in;
   logic valid_ff, valid_in;
   logic word_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff <= '0;
         key1_ff <= '0;
      end else if (csr_valid) begin
         case (sh24_pkg::csr_index_type'(csr_index))
            sh24_pkg::CSR_KEY_LOW:  key0_ff <= csr_data;
            sh24_pkg::CSR_KEY_HIGH: key1_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign rnd = sh24_pkg::sip_round(lanes_ff);

   always_comb begin
      init.a = key0_ff ^ sh24_pkg::IV_A;
      init.b = key1_ff ^ sh24_pkg::IV_B;
      init.c = key0_ff ^ sh24_pkg::IV_C;
      init.d = key1_ff ^ sh24_pkg::IV_D;
      base     = open_ff ? lanes_ff : init;
      len_base = open_ff ? len_ff : '0;
      word_full = (byte_count >= sh24_pkg::FULL_COUNT);
      count_c   = word_full ? sh24_pkg::FULL_COUNT : byte_count;
      len_add   = last ? sh24_pkg::LEN_W'(count_c) : sh24_pkg::LEN_W'(sh24_pkg::BYTES);
      len_in    = len_ff;
      if (cmd.accept) begin
         len_in = len_base + len_add;
      end
      for (int i = 0; i < sh24_pkg::BYTES; i++) begin
         tail[8*i +: 8] = (sh24_pkg::COUNT_W'(i) < count_c) ? message_word[8*i +: 8] : 8'h00;
      end
      tail      = tail | {len_in, {(sh24_pkg::WORD_W - sh24_pkg::LEN_W){1'b0}}};
      len_block = {len_ff, {(sh24_pkg::WORD_W - sh24_pkg::LEN_W){1'b0}}};
   end

   always_comb begin
      lanes_in = lanes_ff;
      block_in = block_ff;
      open_in  = open_ff;
      last_in  = last_ff;
      full_in  = full_ff;
      hash_in  = hash_ff;
      valid_in = valid_ff & ~rsp_tready;
      if (cmd.accept) begin
         block_in   = (!last || word_full) ? message_word : tail;
         lanes_in   = base;
         lanes_in.d = base.d ^ block_in;
         open_in    = 1'b1;
         last_in    = last;
         full_in    = word_full;
      end
      if (cmd.round) begin
         lanes_in = rnd;
         if (cmd.xor_a_block) begin
            lanes_in.a = rnd.a ^ block_ff;
         end
         if (cmd.chain_tail) begin
            lanes_in.d = rnd.d ^ len_block;
            block_in   = len_block;
         end
         if (cmd.xor_c_final) begin
            lanes_in.c = rnd.c ^ sh24_pkg::FINAL_XOR;
         end
      end
      if (cmd.emit) begin
         hash_in  = rnd.a ^ rnd.b ^ rnd.c ^ rnd.d;
         valid_in = 1'b1;
         open_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lanes_ff <= '0;
         len_ff   <= '0;
         open_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         lanes_ff <= lanes_in;
         len_ff   <= len_in;
         open_ff  <= open_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      block_ff <= block_in;
      last_ff  <= last_in;
      full_ff  <= full_in;
      hash_ff  <= hash_in;
   end

   assign status.last     = last_ff;
   assign status.full     = full_ff;
   assign status.out_free = ~valid_ff | rsp_tready;
   assign rsp_tvalid      = valid_ff;
   assign hash_value      = hash_ff;

endmodule
